@@ rtl/segint_pkg.sv @@
// ----------------------------------------------------------------------------
// segint_pkg: shared constants for the segment intersection block
// Default coordinate width and the depth of the queue between the front and
// back halves.
// ----------------------------------------------------------------------------
package segint_pkg;

   localparam int COORD_WIDTH_DEF = 24;
   localparam int QUEUE_DEPTH     = 4;

endpackage

@@ rtl/segint_front.sv @@
// ----------------------------------------------------------------------------
// segint_front: difference, cross product and classification pipeline
// Four stages: coordinate differences, six products, denominator and
// numerators, sign normalisation with the strict interior test.
// ----------------------------------------------------------------------------
module segint_front #(
   parameter int COORD_WIDTH = segint_pkg::COORD_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic [8*COORD_WIDTH-1:0]               in_data,
   input  logic                                   q_full,
   output logic                                   q_push,
   output logic [8*COORD_WIDTH+5-1:0]             q_entry
);
   import segint_pkg::*;

   localparam int W  = COORD_WIDTH;
   localparam int DW = W + 1;
   localparam int PW = 2 * W + 2;
   localparam int NW = 2 * W + 1;

   logic adv;
   logic v1_ff, v2_ff, v3_ff, v4_ff;

   logic signed [W-1:0]  c [8];
   logic signed [DW-1:0] dxa_ff, dya_ff, dxb_ff, dyb_ff, ex_ff, ey_ff;
   logic signed [W-1:0]  ax1_ff, ay1_ff;

   logic signed [PW-1:0] p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   logic signed [DW-1:0] dxa2_ff, dya2_ff;
   logic signed [W-1:0]  ax12_ff, ay12_ff;

   logic signed [PW-1:0] den_ff, an_ff, bn_ff;
   logic signed [DW-1:0] dxa3_ff, dya3_ff;
   logic signed [W-1:0]  ax13_ff, ay13_ff;

   logic signed [PW-1:0] dn_in, an_in, bn_in;
   logic                 hit_in;
   logic                 hit4_ff;
   logic [NW-1:0]        den4_ff, an4_ff;
   logic signed [DW-1:0] dxa4_ff, dya4_ff;
   logic signed [W-1:0]  ax14_ff, ay14_ff;

   assign adv      = !(v4_ff && q_full);
   assign in_ready = adv;
   assign q_push   = v4_ff && !q_full;
   assign q_entry  = {ay14_ff, ax14_ff, dya4_ff, dxa4_ff, an4_ff, den4_ff, hit4_ff};

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         c[i] = in_data[i*W +: W];
      end
   end

   // sign normalisation and strict interior test
   always_comb begin
      dn_in = den_ff;
      an_in = an_ff;
      bn_in = bn_ff;
      if (den_ff < 0) begin
         dn_in = -den_ff;
         an_in = -an_ff;
         bn_in = -bn_ff;
      end
      hit_in = (den_ff != 0) && (an_in > 0) && (bn_in > 0) && (an_in < dn_in)
               && (bn_in < dn_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dxa_ff  <= DW'(c[2]) - DW'(c[0]);
         dya_ff  <= DW'(c[3]) - DW'(c[1]);
         dxb_ff  <= DW'(c[6]) - DW'(c[4]);
         dyb_ff  <= DW'(c[7]) - DW'(c[5]);
         ex_ff   <= DW'(c[0]) - DW'(c[4]);
         ey_ff   <= DW'(c[1]) - DW'(c[5]);
         ax1_ff  <= c[0];
         ay1_ff  <= c[1];

         p0_ff   <= dyb_ff * dxa_ff;
         p1_ff   <= dxb_ff * dya_ff;
         p2_ff   <= dxb_ff * ey_ff;
         p3_ff   <= dyb_ff * ex_ff;
         p4_ff   <= dxa_ff * ey_ff;
         p5_ff   <= dya_ff * ex_ff;
         dxa2_ff <= dxa_ff;
         dya2_ff <= dya_ff;
         ax12_ff <= ax1_ff;
         ay12_ff <= ay1_ff;

         den_ff  <= p0_ff - p1_ff;
         an_ff   <= p2_ff - p3_ff;
         bn_ff   <= p4_ff - p5_ff;
         dxa3_ff <= dxa2_ff;
         dya3_ff <= dya2_ff;
         ax13_ff <= ax12_ff;
         ay13_ff <= ay12_ff;

         hit4_ff <= hit_in;
         den4_ff <= dn_in[NW-1:0];
         an4_ff  <= an_in[NW-1:0];
         dxa4_ff <= dxa3_ff;
         dya4_ff <= dya3_ff;
         ax14_ff <= ax13_ff;
         ay14_ff <= ay13_ff;
      end
   end

endmodule

@@ rtl/segint_queue.sv @@
// ----------------------------------------------------------------------------
// segint_queue: short queue between the front and back halves
// Register file queue with read and write pointers and an occupancy count.
// ----------------------------------------------------------------------------
module segint_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = segint_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);
   import segint_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ff, rd_ff;
   logic [CW-1:0]    cnt_ff;

   assign full     = (cnt_ff == CW'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue read while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH))
      else $error("queue count beyond depth");

endmodule

@@ rtl/segint_back.sv @@
// ----------------------------------------------------------------------------
// segint_back: crossing point interpolation
// Split multiply of the numerator by both deltas, then a restoring divider
// that retires one quotient bit per stage, then the output register.
// ----------------------------------------------------------------------------
module segint_back #(
   parameter int COORD_WIDTH = segint_pkg::COORD_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_empty,
   output logic                       q_pop,
   input  logic [8*COORD_WIDTH+5-1:0] q_entry,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic                       out_hit,
   output logic [COORD_WIDTH-1:0]     out_x,
   output logic [COORD_WIDTH-1:0]     out_y
);
   import segint_pkg::*;

   localparam int W  = COORD_WIDTH;
   localparam int DW = W + 1;
   localparam int NW = 2 * W + 1;
   localparam int LW = W + 1;       // low slice of the numerator
   localparam int HW = NW - LW;     // high slice
   localparam int MW = 3 * W + 1;   // full product
   localparam int SW = 3 + NW + 2 * W;

   logic adv;

   logic                 e_hit;
   logic [NW-1:0]        e_den, e_an;
   logic signed [DW-1:0] e_dxa, e_dya;
   logic [W-1:0]         e_ax1, e_ay1;
   logic [DW-1:0]        magx_full, magy_full;

   logic                 b1v_ff;
   logic [LW+W-1:0]      plx_ff, ply_ff;
   logic [HW+W-1:0]      phx_ff, phy_ff;
   logic [SW-1:0]        b1s_ff;

   logic                 v_ff   [W+1];
   logic [SW-1:0]        s_ff   [W+1];
   logic [NW-1:0]        rx_ff  [W+1];
   logic [NW-1:0]        ry_ff  [W+1];
   logic [W-1:0]         lx_ff  [W+1];
   logic [W-1:0]         ly_ff  [W+1];

   logic [MW-1:0]        numx, numy;

   logic                 o_hit;
   logic [NW-1:0]        o_den;
   logic                 o_sx, o_sy;
   logic [W-1:0]         o_bx, o_by;

   logic                 ov_ff, oh_ff;
   logic [W-1:0]         ox_ff, oy_ff;

   assign adv   = !ov_ff || out_ready;
   assign q_pop = adv && !q_empty;

   assign {e_ay1, e_ax1, e_dya, e_dxa, e_an, e_den, e_hit} = q_entry;
   assign magx_full = e_dxa[DW-1] ? DW'(-e_dxa) : DW'(e_dxa);
   assign magy_full = e_dya[DW-1] ? DW'(-e_dya) : DW'(e_dya);

   assign numx = {phx_ff, LW'(0)} + MW'(plx_ff);
   assign numy = {phy_ff, LW'(0)} + MW'(ply_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         b1v_ff <= 1'b0;
      end else if (adv) begin
         b1v_ff <= q_pop;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         plx_ff <= e_an[LW-1:0] * magx_full[W-1:0];
         ply_ff <= e_an[LW-1:0] * magy_full[W-1:0];
         phx_ff <= e_an[NW-1:LW] * magx_full[W-1:0];
         phy_ff <= e_an[NW-1:LW] * magy_full[W-1:0];
         b1s_ff <= {e_ay1, e_ax1, e_dya[DW-1], e_dxa[DW-1], e_den, e_hit};
      end
   end

   // stage zero of the divider: assemble the products
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= b1v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s_ff[0]  <= b1s_ff;
         rx_ff[0] <= numx[MW-1:W];
         ry_ff[0] <= numy[MW-1:W];
         lx_ff[0] <= numx[W-1:0];
         ly_ff[0] <= numy[W-1:0];
      end
   end

   for (genvar k = 0; k < W; k++) begin : g_div
      logic [NW-1:0] den;
      logic [NW:0]   shx, shy;
      logic          gex, gey;

      assign den = s_ff[k][NW:1];
      assign shx = {rx_ff[k], lx_ff[k][W-1]};
      assign shy = {ry_ff[k], ly_ff[k][W-1]};
      assign gex = shx >= {1'b0, den};
      assign gey = shy >= {1'b0, den};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (adv) begin
            v_ff[k+1] <= v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            s_ff[k+1]  <= s_ff[k];
            rx_ff[k+1] <= gex ? NW'(shx - {1'b0, den}) : shx[NW-1:0];
            ry_ff[k+1] <= gey ? NW'(shy - {1'b0, den}) : shy[NW-1:0];
            lx_ff[k+1] <= {lx_ff[k][W-2:0], gex};
            ly_ff[k+1] <= {ly_ff[k][W-2:0], gey};
         end
      end
   end

   assign {o_by, o_bx, o_sy, o_sx, o_den, o_hit} = s_ff[W];

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (adv) begin
         ov_ff <= v_ff[W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         oh_ff <= o_hit;
         ox_ff <= !o_hit ? '0 : (o_sx ? o_bx - lx_ff[W] : o_bx + lx_ff[W]);
         oy_ff <= !o_hit ? '0 : (o_sy ? o_by - ly_ff[W] : o_by + ly_ff[W]);
      end
   end

   assign out_valid = ov_ff;
   assign out_hit   = oh_ff;
   assign out_x     = ox_ff;
   assign out_y     = oy_ff;

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (v_ff[0] && s_ff[0][0]) |-> (s_ff[0][NW:1] != '0))
      else $error("hit carried with zero denominator");
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (v_ff[W] && o_hit) |-> (rx_ff[W] < o_den && ry_ff[W] < o_den))
      else $error("divider remainder not below denominator");
   a_pop_advances: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> b1v_ff)
      else $error("popped entry lost before the multiplier");

endmodule

@@ rtl/segment_intersection.sv @@
// ----------------------------------------------------------------------------
// segment_intersection: strict crossing test of two 2D segments
// Accepts one segment pair per beat and returns one result beat per pair,
// in order, with the crossing point when the interiors cross.
// ----------------------------------------------------------------------------
// The block takes one pair of segments per clock cycle, unless req_tready is
// low, and returns one result beat per pair in the same order. A front
// pipeline of four stages forms the coordinate differences, the six cross
// products, the denominator and both numerators, and decides the hit exactly;
// a queue of four entries then lets the back half stall on its own. The back
// half multiplies the numerator by each delta in two slices, divides with a
// restoring divider that retires one quotient bit per stage (COORD_WIDTH
// stages) and registers the result; when the output is not held, it sustains
// a rate of one pair per cycle. A miss, a parallel pair or a touch at an
// endpoint gives hit low with a zero point. Coordinates are signed fixed
// point; the fraction width does not enter the arithmetic, as the scale
// cancels in the ratio.
module segment_intersection #(
   parameter int COORD_WIDTH = segint_pkg::COORD_WIDTH_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // tdata, lowest first: ax1, ay1, ax2, ay2, bx1, by1, bx2, by2
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic [8*COORD_WIDTH-1:0]                 req_tdata,
   // tdata, lowest first: hit_x, hit_y, zero fill; tuser: hit
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   output logic [((2*COORD_WIDTH+7)/8)*8-1:0]       rsp_tdata,
   output logic                                     rsp_tuser
);
   import segint_pkg::*;

   localparam int W   = COORD_WIDTH;
   localparam int EW  = 8 * W + 5;
   localparam int OTW = ((2 * W + 7) / 8) * 8;

   logic          q_push, q_pop, q_full, q_empty;
   logic [EW-1:0] q_in, q_out;
   logic [W-1:0]  hit_x, hit_y;

   // front: classify each pair
   segint_front #(.COORD_WIDTH(W)) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_data  (req_tdata),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_entry  (q_in)
   );

   // hold classified pairs while the back half stalls
   segint_queue #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .pop_data  (q_out),
      .full      (q_full),
      .empty     (q_empty)
   );

   // back: interpolate the crossing point
   segint_back #(.COORD_WIDTH(W)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .q_entry   (q_out),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_hit   (rsp_tuser),
      .out_x     (hit_x),
      .out_y     (hit_y)
   );

   // pack the point, zero fill to whole bytes
   assign rsp_tdata = OTW'({hit_y, hit_x});

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (hit_x == '0 && hit_y == '0))
      else $error("miss beat with nonzero point");
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");
   a_ready_low_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> q_full)
      else $error("input held back with room in the queue");

endmodule

@@ test/crossing_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crossing_checker: predicts and checks segment crossing results
// Watches the pair and result channels, works out the crossing of each
// accepted pair and compares every result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module crossing_checker #(
   parameter int CW = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [8*CW-1:0]                 req_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [((2*CW+7)/8)*8-1:0]       rsp_tdata,
   input  logic                            rsp_tuser,
   output int                              fail_count,
   output int                              pending
);

   typedef struct packed {
      logic          hit;
      logic [CW-1:0] px;
      logic [CW-1:0] py;
   } crossing_type;

   crossing_type crossing_q[$];

   assign pending = crossing_q.size();

   task automatic report(input string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      fail_count++;
   endtask

   // exact arithmetic in 128-bit signed vectors
   function automatic crossing_type predict_crossing(input logic [8*CW-1:0] pair);
      logic signed [127:0] c[8];
      logic signed [127:0] dxa, dya, dxb, dyb, ex, ey, den, an, bn, qx, qy;
      crossing_type r;
      for (int i = 0; i < 8; i++) c[i] = 128'(signed'(pair[i*CW +: CW]));
      dxa = c[2] - c[0];  dya = c[3] - c[1];
      dxb = c[6] - c[4];  dyb = c[7] - c[5];
      ex = c[0] - c[4];   ey = c[1] - c[5];
      den = dyb * dxa - dxb * dya;
      an  = dxb * ey - dyb * ex;
      bn  = dxa * ey - dya * ex;
      r = '0;
      if (den != 0) begin
         if (den < 0) begin
            den = -den; an = -an; bn = -bn;
         end
         if (an > 0 && bn > 0 && an < den && bn < den) begin
            // signed division truncates toward zero
            qx = (an * dxa) / den;
            qy = (an * dya) / den;
            r.hit = 1'b1;
            r.px = CW'(c[0] + qx);
            r.py = CW'(c[1] + qy);
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      crossing_type want;
      if (reset) begin
         fail_count = 0;
      end else begin
         if (req_tvalid && req_tready) crossing_q.push_back(predict_crossing(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (crossing_q.size() == 0) begin
               report("result beat with no pair outstanding");
            end else begin
               want = crossing_q.pop_front();
               if (rsp_tuser !== want.hit)
                  report($sformatf("hit got %b want %b", rsp_tuser, want.hit));
               if (rsp_tdata[CW-1:0] !== want.px)
                  report($sformatf("hit_x got %h want %h", rsp_tdata[CW-1:0], want.px));
               if (rsp_tdata[2*CW-1:CW] !== want.py)
                  report($sformatf("hit_y got %h want %h", rsp_tdata[2*CW-1:CW], want.py));
            end
         end
      end
   end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: segment intersection testbench
// Drives directed and random segment pairs with varying idle and stall
// patterns; the checker predicts each crossing and counts mismatches.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CW = segint_pkg::COORD_WIDTH_DEF;
   localparam int RW = ((2*CW+7)/8)*8;
   localparam int MAXC = (1 << (CW-1)) - 1;
   localparam int MINC = -(1 << (CW-1));

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_tvalid = 1'b0;
   logic            req_tready;
   logic [8*CW-1:0] req_tdata = '0;
   logic            rsp_tvalid;
   logic            rsp_tready = 1'b0;
   logic [RW-1:0]   rsp_tdata;
   logic            rsp_tuser;
   int              fail_count;
   int              pending;
   int              send_idle_pct = 0;   // sender gap chance, per cent
   int              stall_pct = 0;       // receiver stall chance, per cent

   always #1 clock = ~clock;

   segment_intersection #(.COORD_WIDTH(CW)) u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   crossing_checker #(.CW(CW)) u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .fail_count(fail_count), .pending(pending)
   );

   // receiver: re-roll ready at each falling edge
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // send one pair; hold valid across back-to-back beats, drop it on a gap
   task automatic send_pair(input int c[8]);
      int j;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      for (j = 0; j < 8; j++) req_tdata[j*CW +: CW] <= CW'(c[j]);
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic int rand_coord(input int span);
      int v;
      case ($urandom_range(3))
         0: v = int'($urandom);                                 // full width
         1: v = $urandom_range(2*span) - span;                  // near origin
         2: v = ($urandom_range(1)) ? MAXC - $urandom_range(15)
                                    : MINC + $urandom_range(15);
         default: v = ($urandom_range(64) - 32) << 8;          // whole units
      endcase
      return int'(signed'(CW'(v)));
   endfunction

   // pair built to cross often: segment B spans a point on segment A
   task automatic send_random(input int span);
      int c[8];
      int px, py, dx, dy;
      if ($urandom_range(3) != 0) begin
         c[0] = rand_coord(span); c[1] = rand_coord(span);
         c[2] = rand_coord(span); c[3] = rand_coord(span);
         px = (c[0] >>> 1) + (c[2] >>> 1);
         py = (c[1] >>> 1) + (c[3] >>> 1);
         dx = $urandom_range(2*span) - span;
         dy = $urandom_range(2*span) - span;
         c[4] = px - dx; c[5] = py - dy; c[6] = px + dx; c[7] = py + dy;
         for (int k = 4; k < 8; k++) c[k] = int'(signed'(CW'(c[k])));
      end else begin
         for (int k = 0; k < 8; k++) c[k] = rand_coord(span);
      end
      send_pair(c);
   endtask

   task automatic drain;
      while (pending != 0) @(posedge clock);
      repeat (CW + 16) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      int d[8];
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // plain crossing of two diagonals
      d = '{0, 0, 2560, 2560, 0, 2560, 2560, 0};                send_pair(d);
      // parallel and collinear pairs
      d = '{0, 0, 2560, 0, 0, 256, 2560, 256};                  send_pair(d);
      d = '{0, 0, 2560, 0, 512, 0, 1024, 0};                    send_pair(d);
      // degenerate point segment
      d = '{100, 100, 100, 100, 0, 0, 500, 500};                send_pair(d);
      // touch at an endpoint, and a T-junction
      d = '{0, 0, 256, 256, 256, 256, 512, 0};                  send_pair(d);
      d = '{0, 0, 512, 0, 256, 0, 256, 512};                    send_pair(d);
      // lines cross outside the segments
      d = '{0, 0, 256, 256, 1024, 0, 768, 256};                 send_pair(d);
      // reversed directions, negative denominators
      d = '{2560, 2560, 0, 0, 2560, 0, 0, 2560};                send_pair(d);
      d = '{-300, 7, 401, -9, 5, -333, -7, 299};                send_pair(d);
      // extremes of the coordinate range
      d = '{MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC};     send_pair(d);
      d = '{MAXC, MINC, MINC, MAXC, MINC, MINC, MAXC, MAXC};     send_pair(d);
      d = '{MINC, 0, MAXC, 1, 0, MINC, 1, MAXC};                 send_pair(d);
      d = '{MAXC, MAXC, MAXC, MAXC, MINC, MINC, MINC, MINC};     send_pair(d);
      d = '{-1, -1, 1, 1, -1, 1, 1, -1};                        send_pair(d);
      // truncation toward zero on odd ratios
      d = '{0, 0, 7, 3, 0, 3, 7, -2};                           send_pair(d);
      d = '{0, 0, -7, -3, 0, -3, -7, 2};                        send_pair(d);

      // idling phases: none, sender, receiver, both
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1) ? 48 : (ph == 3) ? 13 : 0;
         stall_pct     = (ph == 2) ? 48 : (ph == 3) ? 13 : 0;
         for (int n = 0; n < 335; n++) send_random((n % 3 == 0) ? 4000 : 60);
      end
      req_tvalid <= 1'b0;
      stall_pct = 0;
      drain();

      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #200000;
      $display("tb: failure");
      $finish;
   end

endmodule
